@@ rtl/iptt_pkg.sv @@
// Shared types and codes for the indexed priority task table.
package iptt_pkg;

  localparam int OPW   = 2;
  localparam int STW   = 2;
  localparam int UIDW  = 16;
  localparam int TIDW  = 16;
  localparam int PRIOW = 32;

  localparam logic [OPW-1:0] OP_ADD    = 2'd0;
  localparam logic [OPW-1:0] OP_EDIT   = 2'd1;
  localparam logic [OPW-1:0] OP_REMOVE = 2'd2;
  localparam logic [OPW-1:0] OP_EXEC   = 2'd3;

  localparam logic [STW-1:0] ST_OK        = 2'd0;
  localparam logic [STW-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STW-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STW-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic             valid;
    logic [TIDW-1:0]  tid;
    logic [PRIOW-1:0] prio;
    logic [UIDW-1:0]  uid;
  } entry_t;

  typedef struct packed {
    logic clr_wr;
    logic start;
    logic rd_en;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic out_valid;
  } sts_t;

endpackage

@@ rtl/iptt_ctrl.sv @@
// Sequencer for the table clear sweep, entry scan and commit of one command.
module iptt_ctrl #(
  parameter int TABLE_DEPTH = 64,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  iptt_pkg::sts_t sts,
  output iptt_pkg::cmd_t cmd,
  output logic [AW-1:0] addr
);
  import iptt_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign addr       = cnt_r;
  assign cmd.clr_wr = (state_r == S_CLEAR);
  assign cmd.start  = in_valid && in_ready;
  assign cmd.rd_en  = (state_r == S_SCAN);
  assign cmd.commit = (state_r == S_COMMIT) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ rtl/iptt_dp.sv @@
// Task table memory, scan trackers, commit decode and result register.
module iptt_dp #(
  parameter int TABLE_DEPTH = 64,
  parameter int AW = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  iptt_pkg::cmd_t              cmd,
  input  logic [AW-1:0]               addr,
  output iptt_pkg::sts_t              sts,
  input  logic [iptt_pkg::OPW-1:0]    in_opcode,
  input  logic [iptt_pkg::UIDW-1:0]   in_user_id,
  input  logic [iptt_pkg::TIDW-1:0]   in_task_id,
  input  logic [iptt_pkg::PRIOW-1:0]  in_priority_req,
  input  logic                        out_ready,
  output logic [iptt_pkg::STW-1:0]    out_status,
  output logic [iptt_pkg::UIDW-1:0]   out_top_user
);
  import iptt_pkg::*;

  entry_t mem [TABLE_DEPTH];

  logic [OPW-1:0]   op_r;
  logic [UIDW-1:0]  uid_r;
  logic [TIDW-1:0]  tid_r;
  logic [PRIOW-1:0] prio_r;

  entry_t        rd_data_r;
  logic          rd_vld_r;
  logic [AW-1:0] rd_idx_r;

  logic          match_found_r, free_found_r, best_found_r;
  logic [AW-1:0] match_idx_r, free_idx_r, best_idx_r;
  logic [UIDW-1:0]  match_uid_r, best_uid_r;
  logic [TIDW-1:0]  best_tid_r;
  logic [PRIOW-1:0] best_prio_r;

  logic          out_valid_r;
  logic [STW-1:0]  status_r, status_nxt;
  logic [UIDW-1:0] top_r, top_nxt;

  logic          we;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          is_match, is_free, is_best;

  assign sts.out_valid = out_valid_r;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign out_status    = status_r;
  assign out_top_user  = top_r;

  assign is_match = rd_vld_r && rd_data_r.valid && (rd_data_r.tid == tid_r) && !match_found_r;
  assign is_free  = rd_vld_r && !rd_data_r.valid && !free_found_r;
  assign is_best  = rd_vld_r && rd_data_r.valid &&
                    (!best_found_r || (rd_data_r.prio > best_prio_r) ||
                     ((rd_data_r.prio == best_prio_r) && (rd_data_r.tid > best_tid_r)));

  always_comb begin
    we         = 1'b0;
    wr_addr    = addr;
    wr_data    = '0;
    status_nxt = ST_OK;
    top_nxt    = '0;
    if (cmd.clr_wr) begin
      we = 1'b1;
    end else begin
      unique case (op_r)
        OP_ADD: begin
          wr_data = '{valid: 1'b1, tid: tid_r, prio: prio_r, uid: uid_r};
          if (match_found_r) begin
            we      = cmd.commit;
            wr_addr = match_idx_r;
          end else if (free_found_r) begin
            we      = cmd.commit;
            wr_addr = free_idx_r;
          end else begin
            status_nxt = ST_FULL;
          end
        end
        OP_EDIT: begin
          wr_data = '{valid: 1'b1, tid: tid_r, prio: prio_r, uid: match_uid_r};
          wr_addr = match_idx_r;
          if (match_found_r) we = cmd.commit;
          else status_nxt = ST_NOT_FOUND;
        end
        OP_REMOVE: begin
          wr_addr = match_idx_r;
          if (match_found_r) we = cmd.commit;
          else status_nxt = ST_NOT_FOUND;
        end
        OP_EXEC: begin
          wr_addr = best_idx_r;
          if (best_found_r) begin
            we      = cmd.commit;
            top_nxt = best_uid_r;
          end else begin
            status_nxt = ST_EMPTY;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) rd_data_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= addr;
    if (cmd.start) begin
      op_r   <= in_opcode;
      uid_r  <= in_user_id;
      tid_r  <= in_task_id;
      prio_r <= in_priority_req;
    end
    if (is_match) begin
      match_idx_r <= rd_idx_r;
      match_uid_r <= rd_data_r.uid;
    end
    if (is_free) free_idx_r <= rd_idx_r;
    if (is_best) begin
      best_idx_r  <= rd_idx_r;
      best_uid_r  <= rd_data_r.uid;
      best_tid_r  <= rd_data_r.tid;
      best_prio_r <= rd_data_r.prio;
    end
    if (cmd.commit) begin
      status_r <= status_nxt;
      top_r    <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r      <= 1'b0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      best_found_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (cmd.start) begin
        match_found_r <= 1'b0;
        free_found_r  <= 1'b0;
        best_found_r  <= 1'b0;
      end else begin
        if (is_match) match_found_r <= 1'b1;
        if (is_free)  free_found_r  <= 1'b1;
        if (is_best)  best_found_r  <= 1'b1;
      end
      if (cmd.commit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

endmodule

@@ rtl/indexed_priority_task_table_unit.sv @@
// Top level of the indexed priority task table.
//
//   channel | direction | ports
//   --------+-----------+-------------------------------------------------------
//   in      | input     | in_valid/in_ready, in_opcode, in_user_id, in_task_id,
//           |           | in_priority_req
//   out     | output    | out_valid/out_ready, out_status, out_top_user
//
// Each beat runs as a sequence: one table read per entry through the single read
// port of the entry memory, a drain step for the read register, and a commit
// step that writes the entry and loads the result register.
// After reset a clearing sweep over every table entry runs before in_ready rises.
// A waiting result does not block the next input beat; only the commit stalls
// until the result register is free.
module indexed_priority_task_table_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [iptt_pkg::OPW-1:0]    in_opcode,
  input  logic [iptt_pkg::UIDW-1:0]   in_user_id,
  input  logic [iptt_pkg::TIDW-1:0]   in_task_id,
  input  logic [iptt_pkg::PRIOW-1:0]  in_priority_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [iptt_pkg::STW-1:0]    out_status,
  output logic [iptt_pkg::UIDW-1:0]   out_top_user
);
  import iptt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] addr;

  assign out_valid = sts.out_valid;

  iptt_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW(AW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .addr     (addr)
  );

  iptt_dp #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW(AW)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .addr            (addr),
    .sts             (sts),
    .in_opcode       (in_opcode),
    .in_user_id      (in_user_id),
    .in_task_id      (in_task_id),
    .in_priority_req (in_priority_req),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_top_user    (out_top_user)
  );

endmodule
